// File: hdl/lmsfir_pkg.sv
// ----------------------------------------------------------------------------
// lmsfir_pkg
// Shared constants and types for the q1.31 lms adaptive fir core.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsfir_pkg;

    localparam int MAX_TAPS   = 32;
    localparam int IDX_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_W      = $clog2(MAX_TAPS + 1);
    localparam int DATA_W     = 32;
    localparam int ERR_W      = DATA_W + 1;
    localparam int PROD_W     = ERR_W + DATA_W;
    localparam int ACC_W      = 2 * DATA_W + IDX_W + 1;
    localparam int QBITS      = 31;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int TAPS_CFG_W = 6;
    localparam int SHIFT_W    = 5;

    localparam logic [TAPS_CFG_W-1:0] TAPS_RESET  = 6'd16;
    localparam logic [SHIFT_W-1:0]    SHIFT_RESET = 5'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SHIFT  = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_ERR,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/lmsfir_ram.sv
// ----------------------------------------------------------------------------
// lmsfir_ram
// Generic simple dual-port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/lms_adaptive_fir_q31_core.sv
// ----------------------------------------------------------------------------
// lms_adaptive_fir_q31_core
// Q1.31 lms noise canceller: one shared 33x32 multiplier sweeps the active
// taps once to filter and once to adapt, with delay line and weights in rams.
// ----------------------------------------------------------------------------
// flow: an accepted input sample starts the filter sweep, then the error state,
//   the update sweep (one ram read and one multiply per active tap in each sweep)
//   and the done state, which waits for the output register to be free; a new
//   input sample is accepted only in the idle state, after the previous one is done
// reset: weights and delay line read as zero through per-entry valid bits,
//   registers return to 16 taps and a step shift of 10
`default_nettype none

module lms_adaptive_fir_q31_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lmsfir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lmsfir_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [63:0]                        s_axis_tdata,  // reference_sample, desired_sample
    input  wire logic                               s_axis_tlast,  // last_in
    // output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [31:0]                             m_axis_tdata,  // error_sample
    output logic                                    m_axis_tlast   // last_out
);

    import lmsfir_pkg::*;

    // control registers
    state_t                  state_reg, state_next;
    logic [TAPS_CFG_W-1:0]   taps_reg, taps_next;
    logic [SHIFT_W-1:0]      shift_reg, shift_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic [MAX_TAPS-1:0]     dl_vld_reg, dl_vld_next;
    logic [MAX_TAPS-1:0]     w_vld_reg, w_vld_next;
    logic [TAP_W-1:0]        n_reg, n_next;
    logic [TAP_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        dl_addr_reg, dl_addr_next;
    logic [IDX_W-1:0]        w_addr_reg, w_addr_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic                    mul_vld_reg, mul_vld_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic signed [DATA_W-1:0] d_reg, d_next;
    logic                     last_reg, last_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     dl_ok_reg, dl_ok_next;
    logic                     w_ok_reg, w_ok_next;
    logic [IDX_W-1:0]         mul_idx_reg, mul_idx_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] w_hold_reg, w_hold_next;
    logic [DATA_W-1:0]        m_data_reg, m_data_next;
    logic                     m_last_reg, m_last_next;

    // ram ports
    logic                dl_we;
    logic [IDX_W-1:0]    dl_waddr;
    logic [DATA_W-1:0]   dl_rdata;
    logic                w_we;
    logic [DATA_W-1:0]   w_wdata;
    logic [DATA_W-1:0]   w_rdata;

    // datapath
    logic                     in_fire;
    logic                     issue;
    logic                     pass_done;
    logic [IDX_W-1:0]         ptr_dec;
    logic signed [DATA_W-1:0] tap;
    logic signed [DATA_W-1:0] wt;
    logic signed [ERR_W-1:0]  mul_a;
    logic signed [PROD_W-1:0] mul_res;
    logic signed [ACC_W-1:0]  acc_sh;
    logic signed [DATA_W-1:0] y_sat;
    logic signed [ERR_W-1:0]  e_wide;
    logic signed [DATA_W-1:0] e_sat;
    logic signed [33:0]       upd_q;
    logic signed [33:0]       delta;
    logic signed [34:0]       w_sum;
    logic signed [DATA_W-1:0] w_new;

    lmsfir_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (s_axis_tdata[31:0]),
        .raddr (dl_addr_reg),
        .rdata (dl_rdata)
    );

    lmsfir_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (mul_idx_reg),
        .wdata (w_wdata),
        .raddr (w_addr_reg),
        .rdata (w_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign ptr_dec   = (ptr_reg == '0) ? IDX_W'(MAX_TAPS - 1) : ptr_reg - 1'b1;
    assign dl_we     = in_fire;
    assign dl_waddr  = ptr_dec;
    assign issue     = ((state_reg == ST_FILT) || (state_reg == ST_UPD)) && (cnt_reg < n_reg);
    assign pass_done = (cnt_reg == n_reg) && !rd_vld_reg && !mul_vld_reg;

    // never-written entries read as zero
    assign tap   = dl_ok_reg ? $signed(dl_rdata) : '0;
    assign wt    = w_ok_reg ? $signed(w_rdata) : '0;
    assign mul_a = (state_reg == ST_UPD) ? err_reg : ERR_W'(wt);
    assign mul_res = mul_a * tap;

    // y = clamp(floor(acc / 2^31)), e = d - y
    always_comb
    begin
        acc_sh = acc_reg >>> QBITS;
        if ((acc_sh[ACC_W-1:QBITS] == '0) || (acc_sh[ACC_W-1:QBITS] == '1))
        begin
            y_sat = acc_sh[DATA_W-1:0];
        end
        else
        begin
            y_sat = acc_sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        e_wide = ERR_W'(d_reg) - ERR_W'(y_sat);
    end

    always_comb
    begin
        if (err_reg[ERR_W-1] == err_reg[ERR_W-2])
        begin
            e_sat = err_reg[DATA_W-1:0];
        end
        else
        begin
            e_sat = err_reg[ERR_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // weight update: w + ((e*tap >>> 31) >>> step), clamped
    always_comb
    begin
        upd_q = prod_reg[PROD_W-1:QBITS];
        delta = upd_q >>> shift_reg;
        w_sum = 35'(w_hold_reg) + 35'(delta);
        if ((w_sum[34:31] == 4'b0000) || (w_sum[34:31] == 4'b1111))
        begin
            w_new = w_sum[DATA_W-1:0];
        end
        else
        begin
            w_new = w_sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    assign w_we    = (state_reg == ST_UPD) && mul_vld_reg;
    assign w_wdata = w_new;

    always_comb
    begin
        state_next    = state_reg;
        taps_next     = taps_reg;
        shift_next    = shift_reg;
        ptr_next      = ptr_reg;
        dl_vld_next   = dl_vld_reg;
        w_vld_next    = w_vld_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        dl_addr_next  = dl_addr_reg;
        w_addr_next   = w_addr_reg;
        rd_vld_next   = issue;
        mul_vld_next  = rd_vld_reg;
        m_tvalid_next = m_tvalid_reg;

        d_next        = d_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        rd_idx_next   = w_addr_reg;
        dl_ok_next    = dl_vld_reg[dl_addr_reg];
        w_ok_next     = w_vld_reg[w_addr_reg];
        mul_idx_next  = rd_idx_reg;
        prod_next     = mul_res;
        w_hold_next   = wt;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TAPS_IN_USE: taps_next  = cfg_data[TAPS_CFG_W-1:0];
                REG_STEP_SHIFT:  shift_next = cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end

        if (m_axis_tvalid && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // shared tap sweep: ram read, then multiply, then accumulate or write back
        if (issue)
        begin
            cnt_next     = cnt_reg + 1'b1;
            dl_addr_next = (dl_addr_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : dl_addr_reg + 1'b1;
            w_addr_next  = w_addr_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    d_next              = $signed(s_axis_tdata[63:32]);
                    last_next           = s_axis_tlast;
                    ptr_next            = ptr_dec;
                    dl_vld_next[ptr_dec] = 1'b1;
                    if (taps_reg == '0)
                    begin
                        n_next = TAP_W'(1);
                    end
                    else if (int'(taps_reg) > MAX_TAPS)
                    begin
                        n_next = TAP_W'(MAX_TAPS);
                    end
                    else
                    begin
                        n_next = TAP_W'(taps_reg);
                    end
                    cnt_next     = '0;
                    dl_addr_next = ptr_dec;
                    w_addr_next  = '0;
                    acc_next     = '0;
                    state_next   = ST_FILT;
                end
            end
            ST_FILT:
            begin
                if (mul_vld_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (pass_done)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next     = e_wide;
                cnt_next     = '0;
                dl_addr_next = ptr_reg;
                w_addr_next  = '0;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                if (mul_vld_reg)
                begin
                    w_vld_next[mul_idx_reg] = 1'b1;
                end
                if (pass_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = e_sat;
                    m_last_next   = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            taps_reg     <= TAPS_RESET;
            shift_reg    <= SHIFT_RESET;
            ptr_reg      <= '0;
            dl_vld_reg   <= '0;
            w_vld_reg    <= '0;
            n_reg        <= '0;
            cnt_reg      <= '0;
            dl_addr_reg  <= '0;
            w_addr_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            mul_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            taps_reg     <= taps_next;
            shift_reg    <= shift_next;
            ptr_reg      <= ptr_next;
            dl_vld_reg   <= dl_vld_next;
            w_vld_reg    <= w_vld_next;
            n_reg        <= n_next;
            cnt_reg      <= cnt_next;
            dl_addr_reg  <= dl_addr_next;
            w_addr_reg   <= w_addr_next;
            rd_vld_reg   <= rd_vld_next;
            mul_vld_reg  <= mul_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        last_reg    <= last_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        rd_idx_reg  <= rd_idx_next;
        dl_ok_reg   <= dl_ok_next;
        w_ok_reg    <= w_ok_next;
        mul_idx_reg <= mul_idx_next;
        prod_reg    <= prod_next;
        w_hold_reg  <= w_hold_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

endmodule

`default_nettype wire

// File: tb/sv/lms_error_checker.sv
// ----------------------------------------------------------------------------
// lms_error_checker
// Watches the configuration, input and output channels of the lms core. It
// keeps its own delay line, weights and register copies, works out the
// cleaned error sample for every input transaction and compares each output
// transaction with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lms_error_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [lmsfir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lmsfir_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [63:0]                       s_axis_tdata,   // reference_sample, desired_sample
    input  wire logic                              s_axis_tlast,   // last_in
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [31:0]                       m_axis_tdata,   // error_sample
    input  wire logic                              m_axis_tlast,   // last_out
    output int                                     fail_count,
    output int                                     pending
);

    import lmsfir_pkg::*;

    localparam int WIDE_W      = 72;
    localparam int MAX_REPORTS = 100;
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 72'sh7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -72'sh8000_0000;

    typedef struct packed {
        logic [31:0] error_sample;
        logic        last;
    } error_item_t;

    logic signed [31:0]    tap_line [MAX_TAPS];
    logic signed [31:0]    coef [MAX_TAPS];
    logic [TAPS_CFG_W-1:0] taps_cfg;
    logic [SHIFT_W-1:0]    shift_cfg;
    error_item_t           expected_errors [$];
    int                    failures;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_MAX)
            return WIDE_MAX[31:0];
        if (v < WIDE_MIN)
            return WIDE_MIN[31:0];
        return v[31:0];
    endfunction

    // one lms step: filter, error, then weight update with the unclamped error
    task automatic cancel_sample(input logic signed [31:0] x, input logic signed [31:0] d,
                                 output logic [31:0] err_out);
        int                        n;
        int                        i;
        logic signed [WIDE_W-1:0]  a;
        logic signed [WIDE_W-1:0]  b;
        logic signed [WIDE_W-1:0]  acc;
        logic signed [WIDE_W-1:0]  e;
        logic signed [WIDE_W-1:0]  delta;
        logic signed [31:0]        y;
        n = taps_cfg;
        if (n < 1)
            n = 1;
        if (n > MAX_TAPS)
            n = MAX_TAPS;
        for (i = MAX_TAPS - 1; i > 0; i--)
            tap_line[i] = tap_line[i-1];
        tap_line[0] = x;
        acc = '0;
        for (i = 0; i < n; i++)
        begin
            a = coef[i];
            b = tap_line[i];
            acc = acc + a * b;
        end
        y = sat32(acc >>> QBITS);
        a = d;
        b = y;
        e = a - b;
        err_out = sat32(e);
        for (i = 0; i < n; i++)
        begin
            b = tap_line[i];
            delta = ((e * b) >>> QBITS) >>> shift_cfg;
            a = coef[i];
            coef[i] = sat32(a + delta);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        error_item_t  want;
        logic [31:0]  err;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                tap_line[i] = '0;
                coef[i] = '0;
            end
            taps_cfg = TAPS_RESET;
            shift_cfg = SHIFT_RESET;
            expected_errors.delete();
            failures = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TAPS_IN_USE)
                    taps_cfg = cfg_data[TAPS_CFG_W-1:0];
                else if (cfg_index == REG_STEP_SHIFT)
                    shift_cfg = cfg_data[SHIFT_W-1:0];
            end
            // compare before pushing so a result never matches its own cycle's input
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_errors.size() == 0)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: result with nothing expected, error_sample %h last %b",
                                 $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = expected_errors.pop_front();
                    if (m_axis_tdata !== want.error_sample)
                    begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("%0t: error_sample mismatch, expected %h, actual %h",
                                     $time, want.error_sample, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("%0t: last_out mismatch, expected %b, actual %b",
                                     $time, want.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cancel_sample(s_axis_tdata[31:0], s_axis_tdata[63:32], err);
                want.error_sample = err;
                want.last = s_axis_tlast;
                expected_errors.push_back(want);
            end
            fail_count <= failures;
            pending <= expected_errors.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the q1.31 lms noise canceller. Drives directed extremes and
// randomized sample streams under several register settings, with random
// gaps and stalls on both streams and a long output hold-off; the checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import lmsfir_pkg::*;

    localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 173;
    localparam int HOLD_CYCLES   = 600;
    localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;   // reference_sample, desired_sample
    logic                  s_axis_tlast;   // last_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // error_sample
    logic                  m_axis_tlast;   // last_out

    int fail_count;
    int pending;
    int cycle_count;
    bit idle_on;
    int hold_reqs;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lms_adaptive_fir_q31_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    lms_error_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    function automatic logic signed [31:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return Q31_MAX;
            1: return Q31_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // tvalid is only lowered when a gap follows, so it never toggles within one step
    task automatic send_sample(input logic [31:0] x_s, input logic [31:0] d_s, input bit lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d_s, x_s};
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // drain all results and let the update sweep finish before touching registers
    task automatic set_regs(input logic [CFG_DATA_W-1:0] taps_val,
                            input logic [CFG_DATA_W-1:0] shift_val, input bit stray);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_TAPS_IN_USE, taps_val);
        write_reg(REG_STEP_SHIFT, shift_val);
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(REG_STEP_SHIFT + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // output side: random stall per result, plus one long hold-off on request
    initial
    begin
        int stall;
        int holds_done;
        holds_done = 0;
        m_axis_tready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 15) : 0;
            if (hold_reqs != holds_done)
            begin
                stall = HOLD_CYCLES;
                holds_done++;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        int                 kind;
        logic signed [31:0] xs;
        logic signed [31:0] ds;
        logic signed [31:0] prev_x;
        logic [31:0]        r;
        bit                 lst;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        idle_on       = 1'b1;
        hold_reqs     = 0;
        prev_x        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 16 taps, step shift 10, zero weights
        send_sample(Q31_MAX, Q31_MAX, 1'b0);
        send_sample(Q31_MIN, Q31_MIN, 1'b1);
        send_sample(32'sd0, 32'sd0, 1'b0);
        send_sample(-32'sd1, 32'sd1, 1'b0);

        // one tap, full step: weight runs into its clamps, error saturates
        set_regs(8'hC1, 8'hE0, 1'b1);
        send_sample(Q31_MAX, Q31_MAX, 1'b0);
        send_sample(Q31_MAX, Q31_MIN, 1'b0);
        send_sample(Q31_MIN, Q31_MAX, 1'b0);
        send_sample(Q31_MIN, Q31_MIN, 1'b0);
        send_sample(Q31_MAX, Q31_MAX, 1'b0);
        send_sample(32'sd1, -32'sd1, 1'b0);
        send_sample(Q31_MAX, Q31_MAX, 1'b0);
        send_sample(Q31_MIN, Q31_MIN, 1'b1);

        // tap count of zero behaves as one, smallest step
        set_regs(8'h40, 8'd31, 1'b0);
        send_sample(Q31_MAX, Q31_MAX, 1'b0);
        send_sample(Q31_MIN, Q31_MAX, 1'b0);
        send_sample(-32'sd1, Q31_MIN, 1'b0);
        send_sample(32'sd0, Q31_MAX, 1'b1);

        // tap count above the built size behaves as the full size
        set_regs(8'hFF, 8'd0, 1'b1);
        for (int k = 0; k < 8; k++)
            send_sample(k[0] ? Q31_MIN : Q31_MAX, k[1] ? Q31_MAX : Q31_MIN, k == 7);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_regs(8'd32, 8'd31, 1'b0);
                1: set_regs(8'd1, 8'd0, 1'b1);
                2: set_regs(8'hE0, 8'd0, 1'b0);
                3: set_regs(8'd16, 8'd10, 1'b1);
                default: set_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                  1'($urandom_range(0, 1)));
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 40 == 0)
                    idle_on = ($urandom_range(0, 2) != 0);
                if ((ph == 3 || ph == 7) && k == 30)
                    hold_reqs++;
                kind = $urandom_range(0, 9);
                r = $urandom;
                if (kind < 3)
                begin
                    xs = $urandom;
                    ds = $urandom;
                end
                else if (kind < 5)
                begin
                    xs = {{12{r[19]}}, r[19:0]};
                    ds = $signed(32'($urandom_range(0, 1 << 21))) - (32'sd1 <<< 20);
                end
                else if (kind == 5)
                begin
                    xs = extreme_value();
                    ds = extreme_value();
                end
                else
                begin
                    // desired tracks a short filter of the reference plus some noise
                    xs = {{4{r[27]}}, r[27:0]};
                    ds = (xs >>> 1) + (prev_x >>> 2)
                         + $signed(32'($urandom_range(0, 255))) - 32'sd128;
                end
                lst = ($urandom_range(0, 7) == 0);
                prev_x = xs;
                send_sample(xs, ds, lst);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
